// ----- hw/rtl/coab_pkg.sv -----
// Shared constants and types for the cursor overlay alpha blend unit.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package coab_pkg;

    // Default side of the square cursor bitmap, in texels
    localparam int CURSOR_DIM_DEF = 64;
    // Frame extent; pixels at or beyond it pass through uncomposited
    localparam int FRAME_DIM = 8192;

    // Field widths
    localparam int COORD_W = 13;
    localparam int IDX_W   = 12;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 14;
    localparam int EXT_W   = 7;
    localparam int DIFF_W  = POS_W + 1;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [7:0] FULL_ALPHA = 8'hFF;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // Register indexes, byte address divided by four
    typedef enum logic [2:0] {
        REG_ENABLE = 3'd0,
        REG_LEFT   = 3'd1,
        REG_TOP    = 3'd2,
        REG_WIDTH  = 3'd3,
        REG_HEIGHT = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        BM_PASS,
        BM_COPY,
        BM_MIX
    } t_blend_mode;

    // Load enables for the two blend stages
    typedef struct packed {
        logic s3;
        logic out;
    } t_pipe_adv;

endpackage

// ----- hw/rtl/coab_store.sv -----
// Cursor texel store: one write port, one registered read port.
// Depends on coab_pkg for the default bitmap size.
`timescale 1ns / 1ps

module coab_store
    import coab_pkg::*;
#(
    parameter int CURSOR_DIM = CURSOR_DIM_DEF,
    localparam int DEPTH = CURSOR_DIM * CURSOR_DIM,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold the last read word while the pipeline is stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/coab_blend.sv -----
// Premultiplied alpha compositing datapath: multiply stage, then divide and saturate.
// Depends on coab_pkg for the blend mode and stage enable types.
`timescale 1ns / 1ps

module coab_blend
    import coab_pkg::*;
(
    input  logic              i_clk,
    input  t_pipe_adv         i_adv,
    input  logic              i_hit,
    input  logic [WORD_W-1:0] i_texel,
    input  logic [WORD_W-1:0] i_pixel,
    output logic [WORD_W-1:0] o_value
);

    // floor(x / 255), exact for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    logic [7:0]        alpha;
    logic [7:0]        inv;
    t_blend_mode       n_mode;
    t_blend_mode       r_mode;
    logic [15:0]       r_prod [3];
    logic [23:0]       r_src;
    logic [WORD_W-1:0] r_pix;
    logic [WORD_W-1:0] n_value;
    logic [WORD_W-1:0] r_value;

    assign alpha = i_texel[31:24];
    assign inv   = FULL_ALPHA - alpha;

    always_comb begin
        if (!i_hit || alpha == 8'd0) begin
            n_mode = BM_PASS;
        end else if (alpha == FULL_ALPHA) begin
            n_mode = BM_COPY;
        end else begin
            n_mode = BM_MIX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r_mode <= n_mode;
            r_src  <= i_texel[23:0];
            r_pix  <= i_pixel;
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= 16'(i_pixel[8*k +: 8]) * 16'(inv);
            end
        end
    end

    always_comb begin
        logic [8:0] sum;
        sum     = '0;
        n_value = r_pix;
        case (r_mode)
            BM_PASS: n_value = r_pix;
            BM_COPY: n_value = {FULL_ALPHA, r_src};
            BM_MIX: begin
                n_value[31:24] = FULL_ALPHA;
                for (int k = 0; k < 3; k++) begin
                    sum = 9'(r_src[8*k +: 8]) + 9'(div255(r_prod[k]));
                    n_value[8*k +: 8] = sum[8] ? 8'hFF : sum[7:0];
                end
            end
            default: n_value = r_pix;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.out) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

// ----- hw/rtl/cursor_overlay_alpha_blend_unit.sv -----
// Cursor overlay alpha blend unit, top level. Uses coab_pkg, coab_store, coab_blend.
//
// One input channel carries two kinds of word. A load word (kind 0) writes a
// premultiplied cursor texel into the store at texel_index; it gives no output.
// A pixel word (kind 1) is a framebuffer pixel with its column and row; it gives
// exactly one output word, composited with the cursor texel when the pixel lies
// inside the enabled cursor rectangle, else passed through unchanged.
// The cursor position, size and enable sit in APB registers; write them only
// while no word is in flight.
// A pixel accepted into the input stage reaches the output register via the store
// read, multiply and divide/saturate stages. Throughput: one word per cycle unless
// the receiver stalls, set by the single-port store read and three 8x8 multipliers.
// Loads and reads issue in order from one stage, so a pixel sees every earlier
// load without forwarding. The store has no clearing pass; texels read before
// being written are undefined.
// Reset clears all stage valids and the registers; nothing is emitted after it.
// When the receiver stalls, the output word holds and each stage keeps filling
// until it meets an occupied one; o_in_stall rises only when the input stage
// cannot move.
`timescale 1ns / 1ps

module cursor_overlay_alpha_blend_unit
    import coab_pkg::*;
#(
    parameter int CURSOR_DIM = CURSOR_DIM_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  logic [IDX_W-1:0]   i_texel_index,
    input  logic [WORD_W-1:0]  i_texel_value,
    input  logic [COORD_W-1:0] i_pixel_column,
    input  logic [COORD_W-1:0] i_pixel_row,
    input  logic [WORD_W-1:0]  i_pixel_value,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [COORD_W-1:0] o_out_column,
    output logic [COORD_W-1:0] o_out_row,
    output logic [WORD_W-1:0]  o_out_value
);

    localparam int DEPTH = CURSOR_DIM * CURSOR_DIM;
    localparam int AW = $clog2(DEPTH);
    localparam logic [31:0] DEPTH_LIM = 32'(DEPTH);
    localparam logic [8:0] DIM_LIM = 9'(CURSOR_DIM);
    localparam logic [DIFF_W-1:0] FRAME_LIM = DIFF_W'(FRAME_DIM);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic             r_cfg_enable;
    logic [POS_W-1:0] r_cfg_left;
    logic [POS_W-1:0] r_cfg_top;
    logic [EXT_W-1:0] r_cfg_width;
    logic [EXT_W-1:0] r_cfg_height;
    logic             cfg_wr;
    logic [2:0]       cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_enable <= 1'b0;
            r_cfg_left   <= '0;
            r_cfg_top    <= '0;
            r_cfg_width  <= '0;
            r_cfg_height <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ENABLE: r_cfg_enable <= pwdata[0];
                REG_LEFT:   r_cfg_left   <= pwdata[POS_W-1:0];
                REG_TOP:    r_cfg_top    <= pwdata[POS_W-1:0];
                REG_WIDTH:  r_cfg_width  <= pwdata[EXT_W-1:0];
                REG_HEIGHT: r_cfg_height <= pwdata[EXT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, r_cfg_enable};
            REG_LEFT:   prdata = {{(PDATA_W-POS_W){r_cfg_left[POS_W-1]}}, r_cfg_left};
            REG_TOP:    prdata = {{(PDATA_W-POS_W){r_cfg_top[POS_W-1]}}, r_cfg_top};
            REG_WIDTH:  prdata = {{(PDATA_W-EXT_W){1'b0}}, r_cfg_width};
            REG_HEIGHT: prdata = {{(PDATA_W-EXT_W){1'b0}}, r_cfg_height};
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its word moves on
    // ---------------------------------------------------------------
    logic      r_s1_v, r_s2_v, r_s3_v, r_out_v;
    logic      adv1, adv2, adv3, adv_out;
    logic      in_acc;
    t_pipe_adv blend_adv;

    assign adv_out    = !r_out_v || !i_out_stall;
    assign adv3       = !r_s3_v || adv_out;
    assign adv2       = !r_s2_v || adv3;
    assign adv1       = !r_s1_v || adv2;
    assign o_in_stall = !adv1;
    assign in_acc     = i_in_valid && adv1;

    // ---------------------------------------------------------------
    // Stage 1: capture the word, offsets relative to the cursor corner
    // ---------------------------------------------------------------
    logic               r_s1_kind;
    logic [IDX_W-1:0]   r_s1_tidx;
    logic [WORD_W-1:0]  r_s1_tval;
    logic [COORD_W-1:0] r_s1_col, r_s1_row;
    logic [WORD_W-1:0]  r_s1_pix;
    logic [DIFF_W-1:0]  r_s1_cx, r_s1_cy;
    logic [DIFF_W-1:0]  n_s1_cx, n_s1_cy;

    assign n_s1_cx = DIFF_W'($signed({2'b00, i_pixel_column})
                     - $signed({r_cfg_left[POS_W-1], r_cfg_left}));
    assign n_s1_cy = DIFF_W'($signed({2'b00, i_pixel_row})
                     - $signed({r_cfg_top[POS_W-1], r_cfg_top}));

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_kind <= i_kind;
            r_s1_tidx <= i_texel_index;
            r_s1_tval <= i_texel_value;
            r_s1_col  <= i_pixel_column;
            r_s1_row  <= i_pixel_row;
            r_s1_pix  <= i_pixel_value;
            r_s1_cx   <= n_s1_cx;
            r_s1_cy   <= n_s1_cy;
        end
    end

    // Rectangle test, extents saturated to the bitmap side
    logic [8:0]    w_lim, h_lim;
    logic          col_ok, row_ok, cx_ok, cy_ok, s1_hit;
    logic [AW-1:0] s1_raddr;
    logic          st_we, st_re;

    assign w_lim  = ({2'b00, r_cfg_width} > DIM_LIM) ? DIM_LIM : {2'b00, r_cfg_width};
    assign h_lim  = ({2'b00, r_cfg_height} > DIM_LIM) ? DIM_LIM : {2'b00, r_cfg_height};
    assign col_ok = {2'b00, r_s1_col} < FRAME_LIM;
    assign row_ok = {2'b00, r_s1_row} < FRAME_LIM;
    assign cx_ok  = !r_s1_cx[DIFF_W-1] && (r_s1_cx[POS_W-1:0] < {5'b00000, w_lim});
    assign cy_ok  = !r_s1_cy[DIFF_W-1] && (r_s1_cy[POS_W-1:0] < {5'b00000, h_lim});
    assign s1_hit = r_cfg_enable && col_ok && row_ok && cx_ok && cy_ok;

    assign s1_raddr = AW'(r_s1_cy[POS_W-1:0]) * AW'(CURSOR_DIM) + AW'(r_s1_cx[POS_W-1:0]);

    // Loads write and pixels read from this one stage, so store order is word order
    assign st_we = r_s1_v && (r_s1_kind == KIND_LOAD) && adv2
                   && (32'(r_s1_tidx) < DEPTH_LIM);
    assign st_re = r_s1_v && (r_s1_kind == KIND_PIXEL) && adv2;

    // ---------------------------------------------------------------
    // Stage 2: texel comes out of the store
    // ---------------------------------------------------------------
    logic [WORD_W-1:0]  st_rdata;
    logic               r_s2_hit;
    logic [COORD_W-1:0] r_s2_col, r_s2_row;
    logic [WORD_W-1:0]  r_s2_pix;

    coab_store #(
        .CURSOR_DIM(CURSOR_DIM)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(AW'(r_s1_tidx)),
        .i_wdata(r_s1_tval),
        .i_re   (st_re),
        .i_raddr(s1_raddr),
        .o_rdata(st_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (st_re) begin
            r_s2_hit <= s1_hit;
            r_s2_col <= r_s1_col;
            r_s2_row <= r_s1_row;
            r_s2_pix <= r_s1_pix;
        end
    end

    // ---------------------------------------------------------------
    // Stages 3 and output: blend datapath, coordinates ride alongside
    // ---------------------------------------------------------------
    logic [COORD_W-1:0] r_s3_col, r_s3_row;
    logic [COORD_W-1:0] r_out_col, r_out_row;

    assign blend_adv.s3  = adv3 && r_s2_v;
    assign blend_adv.out = adv_out && r_s3_v;

    coab_blend u_blend (
        .i_clk  (i_clk),
        .i_adv  (blend_adv),
        .i_hit  (r_s2_hit),
        .i_texel(st_rdata),
        .i_pixel(r_s2_pix),
        .o_value(o_out_value)
    );

    always_ff @(posedge i_clk) begin
        if (blend_adv.s3) begin
            r_s3_col <= r_s2_col;
            r_s3_row <= r_s2_row;
        end
        if (blend_adv.out) begin
            r_out_col <= r_s3_col;
            r_out_row <= r_s3_row;
        end
    end

    // Stage valids; loads drop out after the store write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (adv1) begin
                r_s1_v <= i_in_valid;
            end
            if (adv2) begin
                r_s2_v <= r_s1_v && (r_s1_kind == KIND_PIXEL);
            end
            if (adv3) begin
                r_s3_v <= r_s2_v;
            end
            if (adv_out) begin
                r_out_v <= r_s3_v;
            end
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_out_column = r_out_col;
    assign o_out_row    = r_out_row;

endmodule

// ----- hw/rtl/coab_checker.sv -----
// Port-level checks for the cursor overlay alpha blend unit, bound to the top level.
// Depends on coab_pkg for field widths.
`timescale 1ns / 1ps

module coab_checker
    import coab_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_stall,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input logic [COORD_W-1:0] i_out_column,
    input logic [COORD_W-1:0] i_out_row,
    input logic [WORD_W-1:0]  i_out_value
);

    logic in_acc;
    assign in_acc = i_in_valid && !i_in_stall;

    // A stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_value)
            && $stable(i_out_column) && $stable(i_out_row))
        else $error("output word changed under stall");

    // Reset empties the output
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A free output never pushes back on the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !i_in_stall)
        else $error("input stalled while output is free");

    // With no input and no output stall, the pipeline drains and the output valid falls
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!in_acc && !i_out_stall) ##1 (!in_acc && !i_out_stall)
            ##1 (!in_acc && !i_out_stall) ##1 (!in_acc && !i_out_stall)
            |=> !i_out_valid)
        else $error("output word without a matching input");

endmodule

bind cursor_overlay_alpha_blend_unit coab_checker u_coab_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_column(o_out_column),
    .i_out_row   (o_out_row),
    .i_out_value (o_out_value)
);

// ----- tb/coab_overlay_checker.sv -----
// Checker for the cursor overlay alpha blend unit: snoops APB writes and both word channels,
// predicts each composited pixel and compares it with the output word. Depends on coab_pkg.
`timescale 1ns / 1ps

module coab_overlay_checker
    import coab_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_kind,
    input  logic [IDX_W-1:0]   i_texel_index,
    input  logic [WORD_W-1:0]  i_texel_value,
    input  logic [COORD_W-1:0] i_pixel_column,
    input  logic [COORD_W-1:0] i_pixel_row,
    input  logic [WORD_W-1:0]  i_pixel_value,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [COORD_W-1:0] i_out_column,
    input  logic [COORD_W-1:0] i_out_row,
    input  logic [WORD_W-1:0]  i_out_value,
    output int                 o_mismatches,
    output int                 o_pixels_in_flight
);

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [WORD_W-1:0]  value;
    } t_pixel_word;

    localparam int TEXELS = CURSOR_DIM_DEF * CURSOR_DIM_DEF;

    logic [WORD_W-1:0] cursor_texels [0:TEXELS-1];
    logic              cur_enable;
    int                cur_left;
    int                cur_top;
    logic [EXT_W-1:0]  cur_width;
    logic [EXT_W-1:0]  cur_height;
    t_pixel_word       expected_pixels [$];
    t_pixel_word       want;
    t_pixel_word       got;

    // Premultiplied "over": src + dst*(255-a)/255 per color, saturated, alpha forced opaque; alpha 0 returns the pixel
    function automatic logic [WORD_W-1:0] mix_texel(logic [WORD_W-1:0] texel,
                                                    logic [WORD_W-1:0] pix);
        logic [7:0]        alpha;
        int unsigned       inv;
        int unsigned       src;
        int unsigned       dst;
        int unsigned       sum;
        logic [WORD_W-1:0] res;
        int                ch;
        alpha = texel[31:24];
        if (alpha == 8'd0) return pix;
        if (alpha == FULL_ALPHA) return {FULL_ALPHA, texel[23:0]};
        inv = FULL_ALPHA - alpha;
        res = {FULL_ALPHA, 24'd0};
        for (ch = 0; ch < 3; ch++) begin
            src = texel[ch*8 +: 8];
            dst = pix[ch*8 +: 8];
            sum = src + (dst * inv) / FULL_ALPHA;
            res[ch*8 +: 8] = (sum > FULL_ALPHA) ? FULL_ALPHA : sum[7:0];
        end
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] overlay_pixel(logic [COORD_W-1:0] col,
                                                        logic [COORD_W-1:0] row,
                                                        logic [WORD_W-1:0] pix);
        int w;
        int h;
        int cx;
        int cy;
        w  = (cur_width > CURSOR_DIM_DEF) ? CURSOR_DIM_DEF : int'(cur_width);
        h  = (cur_height > CURSOR_DIM_DEF) ? CURSOR_DIM_DEF : int'(cur_height);
        cx = int'(col) - cur_left;
        cy = int'(row) - cur_top;
        if (cur_enable && col < FRAME_DIM && row < FRAME_DIM &&
            cx >= 0 && cy >= 0 && cx < w && cy < h)
            return mix_texel(cursor_texels[cy * CURSOR_DIM_DEF + cx], pix);
        return pix;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_enable   = 1'b0;
            cur_left     = 0;
            cur_top      = 0;
            cur_width    = '0;
            cur_height   = '0;
            o_mismatches = 0;
            expected_pixels.delete();
        end else begin
            // register writes are to come only while no word is in flight; the checker does not enforce it
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[PADDR_W-1:2]))
                    REG_ENABLE: cur_enable = pwdata[0];
                    REG_LEFT:   cur_left   = int'($signed(pwdata[POS_W-1:0]));
                    REG_TOP:    cur_top    = int'($signed(pwdata[POS_W-1:0]));
                    REG_WIDTH:  cur_width  = pwdata[EXT_W-1:0];
                    REG_HEIGHT: cur_height = pwdata[EXT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_kind == KIND_LOAD) begin
                    cursor_texels[i_texel_index] = i_texel_value;
                end else begin
                    want.column = i_pixel_column;
                    want.row    = i_pixel_row;
                    want.value  = overlay_pixel(i_pixel_column, i_pixel_row, i_pixel_value);
                    expected_pixels.push_back(want);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                got.column = i_out_column;
                got.row    = i_out_row;
                got.value  = i_out_value;
                if (expected_pixels.size() == 0) begin
                    $display("%0t: output word with none expected, got col %0d row %0d %h",
                             $time, got.column, got.row, got.value);
                    o_mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.column !== want.column) begin
                        $display("%0t: out_column expected %0d, actual %0d",
                                 $time, want.column, got.column);
                        o_mismatches++;
                    end
                    if (got.row !== want.row) begin
                        $display("%0t: out_row expected %0d, actual %0d",
                                 $time, want.row, got.row);
                        o_mismatches++;
                    end
                    if (got.value !== want.value) begin
                        $display("%0t: out_value expected %h, actual %h (col %0d row %0d)",
                                 $time, want.value, got.value, want.column, want.row);
                        o_mismatches++;
                    end
                end
            end
        end
        o_pixels_in_flight = expected_pixels.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// Top of the cursor overlay testbench: clock, reset, APB setup and word stimulus.
// Depends on coab_pkg, cursor_overlay_alpha_blend_unit and coab_overlay_checker.
`timescale 1ns / 1ps

module tb_top;
    import coab_pkg::*;

    localparam int TEXELS      = CURSOR_DIM_DEF * CURSOR_DIM_DEF;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 160;
    // the output register sits behind the pipeline stages; give loads room to retire
    localparam int SETTLE      = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_kind;
    logic [IDX_W-1:0]   i_texel_index;
    logic [WORD_W-1:0]  i_texel_value;
    logic [COORD_W-1:0] i_pixel_column;
    logic [COORD_W-1:0] i_pixel_row;
    logic [WORD_W-1:0]  i_pixel_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [COORD_W-1:0] o_out_column;
    logic [COORD_W-1:0] o_out_row;
    logic [WORD_W-1:0]  o_out_value;

    int mismatches;
    int pixels_in_flight;

    // Sender gap and receiver stall odds, in percent, set per phase
    int idle_pct;
    int stall_pct;
    int words_sent;

    // Stimulus-side copy of the cursor window, used to keep pixels off texels that
    // were never loaded and to aim scan runs near the cursor
    bit cfg_enable;
    int cfg_left;
    int cfg_top;
    int cfg_w;
    int cfg_h;
    bit texel_loaded [0:TEXELS-1];

    cursor_overlay_alpha_blend_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_texel_index  (i_texel_index),
        .i_texel_value  (i_texel_value),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .i_pixel_value  (i_pixel_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_column   (o_out_column),
        .o_out_row      (o_out_row),
        .o_out_value    (o_out_value)
    );

    coab_overlay_checker u_overlay_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .pready             (pready),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_kind             (i_kind),
        .i_texel_index      (i_texel_index),
        .i_texel_value      (i_texel_value),
        .i_pixel_column     (i_pixel_column),
        .i_pixel_row        (i_pixel_row),
        .i_pixel_value      (i_pixel_value),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_out_column       (o_out_column),
        .i_out_row          (o_out_row),
        .i_out_value        (o_out_value),
        .o_mismatches       (mismatches),
        .o_pixels_in_flight (pixels_in_flight)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run (about 1.3k words)
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver side: redraw the stall at every falling edge
    always @(negedge i_clk) begin
        i_out_stall = ($urandom_range(99) < stall_pct);
    end

    // Present one word at a falling edge, hold it until accepted, return at the
    // next falling edge. Gaps drop valid for whole cycles.
    task automatic send_word(logic kind, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] tval,
                             logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                             logic [WORD_W-1:0] pval);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_kind         = kind;
        i_texel_index  = idx;
        i_texel_value  = tval;
        i_pixel_column = col;
        i_pixel_row    = row;
        i_pixel_value  = pval;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        words_sent++;
    endtask

    // Store address that a pixel would read under the current window, or -1
    function automatic int cursor_hit(int col, int row);
        int cx;
        int cy;
        cx = col - cfg_left;
        cy = row - cfg_top;
        if (cfg_enable && cx >= 0 && cy >= 0 && cx < cfg_w && cy < cfg_h)
            return cy * CURSOR_DIM_DEF + cx;
        return -1;
    endfunction

    // Alpha 0 and 255 get a fair share so all three blend modes show up
    function automatic logic [WORD_W-1:0] random_texel();
        logic [WORD_W-1:0] colors;
        int                pick;
        logic [7:0]        alpha;
        colors = $urandom;
        pick   = $urandom_range(9);
        if (pick < 2) alpha = 8'd0;
        else if (pick < 4) alpha = FULL_ALPHA;
        else alpha = 8'($urandom_range(254, 1));
        return {alpha, colors[23:0]};
    endfunction

    task automatic send_load(int idx, logic [WORD_W-1:0] texel);
        texel_loaded[idx] = 1'b1;
        send_word(KIND_LOAD, IDX_W'(idx), texel, COORD_W'($urandom), COORD_W'($urandom),
                  $urandom);
    endtask

    // Load the texel first when the pixel would otherwise read an empty entry
    task automatic send_pixel(int col, int row, logic [WORD_W-1:0] value);
        int addr;
        addr = cursor_hit(col, row);
        if (addr >= 0 && !texel_loaded[addr])
            send_load(addr, random_texel());
        send_word(KIND_PIXEL, IDX_W'($urandom), $urandom, COORD_W'(col), COORD_W'(row),
                  value);
    endtask

    task automatic write_reg(t_reg_idx idx, int value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_ENABLE: cfg_enable = value[0];
            REG_LEFT:   cfg_left   = int'($signed(value[POS_W-1:0]));
            REG_TOP:    cfg_top    = int'($signed(value[POS_W-1:0]));
            REG_WIDTH:  cfg_w = (value[EXT_W-1:0] > CURSOR_DIM_DEF) ? CURSOR_DIM_DEF
                                                                   : value[EXT_W-1:0];
            REG_HEIGHT: cfg_h = (value[EXT_W-1:0] > CURSOR_DIM_DEF) ? CURSOR_DIM_DEF
                                                                   : value[EXT_W-1:0];
            default: ;
        endcase
    endtask

    // Hold off new words until every pixel has come out, then let loads retire
    task automatic drain();
        i_in_valid = 1'b0;
        while (pixels_in_flight != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_window(bit en, int left, int top, int w, int h);
        write_reg(REG_ENABLE, en);
        write_reg(REG_LEFT, left);
        write_reg(REG_TOP, top);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // Mostly near the frame origin, sometimes pinned to or hanging past an edge
    function automatic int pick_offset();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return -8192;
        if (pick == 1) return 8191;
        if (pick == 2) return int'($urandom_range(16383)) - 8192;
        if (pick == 3) return 8191 - int'($urandom_range(70));
        return int'($urandom_range(300)) - 60;
    endfunction

    // Zero, full, in-range and oversized extents; the block clamps oversized ones to full
    function automatic int pick_extent();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 0;
        if (pick == 1) return CURSOR_DIM_DEF;
        if (pick == 2) return 127;
        if (pick == 3) return $urandom_range(126, 65);
        return $urandom_range(CURSOR_DIM_DEF, 1);
    endfunction

    // Coordinate in a margin around the cursor span, or anywhere if that falls off-frame
    function automatic int window_coord(int origin, int extent);
        int v;
        v = origin - 2 + int'($urandom_range(extent + 4));
        if (v < 0 || v >= FRAME_DIM) v = $urandom_range(FRAME_DIM - 1);
        return v;
    endfunction

    task automatic scan_run();
        int row;
        int col;
        int len;
        int k;
        row = window_coord(cfg_top, cfg_h);
        col = window_coord(cfg_left, cfg_w);
        len = $urandom_range(12, 1);
        for (k = 0; k < len && col + k < FRAME_DIM; k++)
            send_pixel(col + k, row, $urandom);
    endtask

    initial begin
        int phase;
        int pick;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_in_valid     = 1'b0;
        i_kind         = KIND_LOAD;
        i_texel_index  = '0;
        i_texel_value  = '0;
        i_pixel_column = '0;
        i_pixel_row    = '0;
        i_pixel_value  = '0;
        i_out_stall    = 1'b0;
        idle_pct       = 0;
        stall_pct      = 0;
        words_sent     = 0;
        cfg_enable     = 1'b0;
        cfg_left       = 0;
        cfg_top        = 0;
        cfg_w          = 0;
        cfg_h          = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: a 4x2 cursor at (100,50), texels covering every blend case
        write_window(1'b1, 100, 50, 4, 2);
        send_load(0, 32'h0012_3456);                    // transparent
        send_load(1, 32'hFFA0_B0C0);                    // opaque, copy colors
        send_load(2, 32'h80FF_FFFF);                    // mix that saturates
        send_load(3, 32'h0100_0000);                    // nearly transparent
        send_load(CURSOR_DIM_DEF, 32'hFE01_0203);
        send_load(CURSOR_DIM_DEF + 1, 32'h7F7F_7F7F);
        send_load(TEXELS - 1, 32'hFFFF_FFFF);           // top index, never read here
        send_pixel(100, 50, 32'hFFFF_FFFF);
        send_pixel(101, 50, 32'h0000_0000);
        send_pixel(102, 50, 32'hFFFF_FFFF);
        send_pixel(103, 50, 32'h8080_8080);
        send_pixel(100, 51, 32'h1234_5678);
        send_pixel(101, 51, 32'hFFFF_FFFF);
        // one step outside each edge of the rectangle
        send_pixel(99, 50, $urandom);
        send_pixel(104, 50, $urandom);
        send_pixel(100, 49, $urandom);
        send_pixel(100, 52, $urandom);
        send_pixel(0, 0, 32'h0000_0000);
        send_pixel(FRAME_DIM - 1, FRAME_DIM - 1, 32'hFFFF_FFFF);
        // cursor off: the inside pixel passes through
        drain();
        write_reg(REG_ENABLE, 0);
        send_pixel(100, 50, 32'hFFFF_FFFF);
        // bottom-right corner of the frame with oversized extents clamped to full
        drain();
        write_window(1'b1, FRAME_DIM - 2, FRAME_DIM - 2, 127, 127);
        send_pixel(FRAME_DIM - 1, FRAME_DIM - 1, $urandom);
        send_pixel(FRAME_DIM - 2, FRAME_DIM - 1, $urandom);
        // most negative origin and an empty cursor
        drain();
        write_window(1'b1, -8192, -8192, 0, 0);
        send_pixel(0, 0, $urandom);

        // Random phases: fresh window each time, idling mode rotates
        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            idle_pct  = 0;
            stall_pct = 0;
            write_window($urandom_range(9) != 0, pick_offset(), pick_offset(),
                         pick_extent(), pick_extent());
            case (phase % 4)
                1: idle_pct = 67;
                2: stall_pct = 67;
                3: begin
                    idle_pct  = 21;
                    stall_pct = 21;
                end
                default: ;
            endcase
            words_sent = 0;
            while (words_sent < PHASE_WORDS) begin
                pick = $urandom_range(99);
                if (pick < 12)
                    send_load($urandom_range(TEXELS - 1), random_texel());
                else if (pick < 25)
                    send_pixel($urandom_range(FRAME_DIM - 1), $urandom_range(FRAME_DIM - 1),
                               $urandom);
                else
                    scan_run();
            end
        end

        idle_pct  = 0;
        stall_pct = 0;
        drain();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
